// File: sv/srg_pkg.sv
// Package for the subtractive random generator: constants, codes, control types, helpers.
package srg_pkg;

    // Field widths
    localparam int DATA_W  = 30;
    localparam int SEED_W  = 29;
    localparam int IDX_W   = 6;
    localparam int MAG_W   = 28;

    // Scheme constants
    localparam logic [DATA_W-1:0] RG_MOD     = 30'd1000000000;
    localparam logic [DATA_W-1:0] RG_MAX     = 30'd999999999;
    localparam logic [MAG_W-1:0]  SEED_MAX   = 28'd161803398;
    localparam logic [IDX_W-1:0]  LAG_LAST   = 6'd54;   // address of table word 55
    localparam logic [IDX_W-1:0]  FILL_STEP  = 6'd21;
    localparam logic [IDX_W-1:0]  LAG_LEN    = 6'd55;
    localparam logic [IDX_W-1:0]  MIX_OFFSET = 6'd31;   // address lag between mixed words
    localparam logic [IDX_W-1:0]  SECOND_START = 6'd31;
    localparam logic [IDX_W-1:0]  FILL_LAST  = 6'd53;   // 54 fill steps, counted from zero
    localparam logic [1:0]        PASS_LAST  = 2'd3;    // four mixing passes

    // Word select codes beyond the table
    localparam logic [IDX_W-1:0]  SEL_FIRST  = 6'd55;
    localparam logic [IDX_W-1:0]  SEL_SECOND = 6'd56;

    // Command codes
    typedef enum logic [1:0] {
        CMD_RESEED = 2'd0,
        CMD_DRAW   = 2'd1,
        CMD_READ   = 2'd2,
        CMD_WRITE  = 2'd3
    } srg_cmd_t;

    // Result kinds
    localparam logic KIND_RANDOM = 1'b0;
    localparam logic KIND_STATE  = 1'b1;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_MAG,
        ST_SEED_INIT,
        ST_SEED_FILL,
        ST_MIX_RD,
        ST_MIX_WR,
        ST_DRAW_RD,
        ST_DRAW_WR,
        ST_READ_RD,
        ST_READ_OUT,
        ST_WRITE
    } srg_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic cap;        // capture the accepted item
        logic mag_ld;     // load saturated seed magnitude
        logic fill_init;  // write word 55, set fill and mix pointers
        logic fill_step;  // one fill step
        logic mix_rd;     // read the two words of one mix step
        logic mix_wr;     // write the mixed word, advance pointers
        logic seed_done;  // set indices after reseed
        logic draw_rd;    // advance indices, read both words
        logic draw_wr;    // write the difference, load result
        logic read_rd;    // read the selected table word
        logic read_out;   // load the state word result
        logic wr;         // write the selected state word
    } srg_ctl_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
    } srg_sts_t;

    // Difference modulo RG_MOD of two residues
    function automatic logic [DATA_W-1:0] sub_mod(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W:0] d;
        logic [DATA_W:0] w;
        d = {1'b0, a} - {1'b0, b};
        w = d + {1'b0, RG_MOD};
        return d[DATA_W] ? w[DATA_W-1:0] : d[DATA_W-1:0];
    endfunction

endpackage

// File: sv/subtractive_random_generator.sv
// Top level of the subtractive random generator: controller plus datapath.
//
//  channel | direction | handshake           | fields
//  --------+-----------+---------------------+---------------------------------
//  in      | input     | in_valid / in_stall | cmd, seed, word_index, word_value
//  out     | output    | out_valid/out_stall | data, kind
//
// One item at a time. A draw or a read registers the two-port table read in its read state,
// then loads the result register (subtract and write back for a draw) once the output
// register is free; a write completes in its write state. A reseed runs acceptance, the
// seed magnitude load, 55 table fills (word 55, then 54 steps), then 4 x 55 mix steps,
// each a read and then a write through the table port.
// Reset is asynchronous and clears the table valid bits, so the table reads zero.
// A stalled result holds the next draw or read in its final state.
module subtractive_random_generator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         cmd,
    input  logic signed [srg_pkg::SEED_W-1:0]  seed,
    input  logic [srg_pkg::IDX_W-1:0]          word_index,
    input  logic [srg_pkg::DATA_W-1:0]         word_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [srg_pkg::DATA_W-1:0]         data,
    output logic                               kind
);

    srg_pkg::srg_ctl_t ctl;
    srg_pkg::srg_sts_t sts;

    // Sequencer
    srg_ctl u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts),
        .ctl      (ctl)
    );

    // Table, indices and result register
    srg_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .seed       (seed),
        .word_index (word_index),
        .word_value (word_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data       (data),
        .kind       (kind)
    );

endmodule

// File: sv/srg_ctl.sv
// Controller state machine for the subtractive random generator.
module srg_ctl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    input  srg_pkg::srg_sts_t   sts,
    output srg_pkg::srg_ctl_t   ctl
);

    srg_pkg::srg_state_t state_reg, state_next;
    srg_pkg::srg_cmd_t   cmd_reg, cmd_next;
    logic [5:0]          step_cnt_reg, step_cnt_next;
    logic [1:0]          pass_cnt_reg, pass_cnt_next;

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= srg_pkg::ST_IDLE;
            cmd_reg      <= srg_pkg::CMD_RESEED;
            step_cnt_reg <= '0;
            pass_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cmd_reg      <= cmd_next;
            step_cnt_reg <= step_cnt_next;
            pass_cnt_reg <= pass_cnt_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        step_cnt_next = step_cnt_reg;
        pass_cnt_next = pass_cnt_reg;
        ctl           = '0;
        in_stall      = (state_reg != srg_pkg::ST_IDLE);

        case (state_reg)
            srg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.cap  = 1'b1;
                    cmd_next = srg_pkg::srg_cmd_t'(cmd);
                    case (srg_pkg::srg_cmd_t'(cmd))
                        srg_pkg::CMD_RESEED: state_next = srg_pkg::ST_SEED_MAG;
                        srg_pkg::CMD_DRAW:   state_next = srg_pkg::ST_DRAW_RD;
                        srg_pkg::CMD_READ:   state_next = srg_pkg::ST_READ_RD;
                        srg_pkg::CMD_WRITE:  state_next = srg_pkg::ST_WRITE;
                        default:             state_next = srg_pkg::ST_IDLE;
                    endcase
                end
            end
            srg_pkg::ST_SEED_MAG:
            begin
                ctl.mag_ld = 1'b1;
                state_next = srg_pkg::ST_SEED_INIT;
            end
            srg_pkg::ST_SEED_INIT:
            begin
                ctl.fill_init = 1'b1;
                step_cnt_next = '0;
                state_next    = srg_pkg::ST_SEED_FILL;
            end
            srg_pkg::ST_SEED_FILL:
            begin
                ctl.fill_step = 1'b1;
                if (step_cnt_reg == srg_pkg::FILL_LAST)
                begin
                    step_cnt_next = '0;
                    pass_cnt_next = '0;
                    state_next    = srg_pkg::ST_MIX_RD;
                end
                else
                begin
                    step_cnt_next = step_cnt_reg + 6'd1;
                end
            end
            srg_pkg::ST_MIX_RD:
            begin
                ctl.mix_rd = 1'b1;
                state_next = srg_pkg::ST_MIX_WR;
            end
            srg_pkg::ST_MIX_WR:
            begin
                ctl.mix_wr = 1'b1;
                state_next = srg_pkg::ST_MIX_RD;
                if (step_cnt_reg == srg_pkg::LAG_LAST)
                begin
                    step_cnt_next = '0;
                    if (pass_cnt_reg == srg_pkg::PASS_LAST)
                    begin
                        ctl.seed_done = 1'b1;
                        state_next    = srg_pkg::ST_IDLE;
                    end
                    else
                    begin
                        pass_cnt_next = pass_cnt_reg + 2'd1;
                    end
                end
                else
                begin
                    step_cnt_next = step_cnt_reg + 6'd1;
                end
            end
            srg_pkg::ST_DRAW_RD:
            begin
                ctl.draw_rd = 1'b1;
                state_next  = srg_pkg::ST_DRAW_WR;
            end
            srg_pkg::ST_DRAW_WR:
            begin
                // hold until the output register is free
                if (sts.out_free)
                begin
                    ctl.draw_wr = 1'b1;
                    state_next  = srg_pkg::ST_IDLE;
                end
            end
            srg_pkg::ST_READ_RD:
            begin
                ctl.read_rd = 1'b1;
                state_next  = srg_pkg::ST_READ_OUT;
            end
            srg_pkg::ST_READ_OUT:
            begin
                if (sts.out_free)
                begin
                    ctl.read_out = 1'b1;
                    state_next   = srg_pkg::ST_IDLE;
                end
            end
            srg_pkg::ST_WRITE:
            begin
                ctl.wr     = (cmd_reg == srg_pkg::CMD_WRITE);
                state_next = srg_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = srg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/srg_dp.sv
// Datapath for the subtractive random generator: lag table, indices, seeding and output register.
module srg_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  srg_pkg::srg_ctl_t           ctl,
    output srg_pkg::srg_sts_t           sts,
    input  logic signed [srg_pkg::SEED_W-1:0] seed,
    input  logic [srg_pkg::IDX_W-1:0]   word_index,
    input  logic [srg_pkg::DATA_W-1:0]  word_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [srg_pkg::DATA_W-1:0]  data,
    output logic                        kind
);

    localparam int DW = srg_pkg::DATA_W;
    localparam int IW = srg_pkg::IDX_W;
    localparam int NW = 55;

    // Lag table and its valid bits
    logic [DW-1:0]   lag_mem [0:NW-1];
    logic [NW-1:0]   lag_vld_reg;

    // Captured item
    logic [srg_pkg::SEED_W-1:0] seed_reg;
    logic [IW-1:0]   idx_reg;
    logic [DW-1:0]   val_reg;

    // Indices and sequencing pointers
    logic [IW-1:0]   first_reg, first_next;
    logic [IW-1:0]   second_reg, second_next;
    logic [IW-1:0]   pos_reg, pos_next;
    logic [IW-1:0]   ak_reg, ak_next;
    logic [IW-1:0]   bk_reg, bk_next;
    logic [srg_pkg::MAG_W-1:0] mag_reg;
    logic [DW-1:0]   mj_reg, mj_next;
    logic [DW-1:0]   mk_reg, mk_next;

    // Read port registers
    logic [DW-1:0]   mem_a_reg, mem_b_reg;
    logic            vld_a_reg, vld_b_reg;
    logic [DW-1:0]   rd_a, rd_b;

    // Output register
    logic            out_valid_reg;
    logic [DW-1:0]   data_reg;
    logic            kind_reg;

    // Combinational helpers
    logic [srg_pkg::SEED_W-1:0] seed_abs;
    logic [srg_pkg::MAG_W-1:0]  mag_sat;
    logic [srg_pkg::MAG_W-1:0]  mj_init;
    logic [IW-1:0]   draw_a, draw_b;
    logic [IW:0]     pos_sum;
    logic [DW-1:0]   diff;
    logic            rd_en;
    logic [IW-1:0]   rd_addr_a, rd_addr_b;
    logic            we;
    logic [IW-1:0]   wa;
    logic [DW-1:0]   wd;
    logic [DW-1:0]   state_word;

    // Seed magnitude, saturated
    always_comb
    begin
        seed_abs = seed_reg[srg_pkg::SEED_W-1] ? (~seed_reg + 29'd1) : seed_reg;
        mag_sat  = (seed_abs > {1'b0, srg_pkg::SEED_MAX}) ? srg_pkg::SEED_MAX
                                                          : seed_abs[srg_pkg::MAG_W-1:0];
        mj_init  = srg_pkg::SEED_MAX - mag_reg;
    end

    // Read data, unwritten entries read as zero
    assign rd_a = vld_a_reg ? mem_a_reg : '0;
    assign rd_b = vld_b_reg ? mem_b_reg : '0;
    assign diff = srg_pkg::sub_mod(rd_a, rd_b);

    // Draw addresses: index advances over 1..55, address is index minus one
    assign draw_a = (first_reg >= srg_pkg::LAG_LEN) ? '0 : first_reg;
    assign draw_b = (second_reg >= srg_pkg::LAG_LEN) ? '0 : second_reg;

    // Read address select
    always_comb
    begin
        rd_en     = ctl.mix_rd | ctl.draw_rd | ctl.read_rd;
        rd_addr_a = idx_reg;
        rd_addr_b = bk_reg;
        if (ctl.mix_rd)
        begin
            rd_addr_a = ak_reg;
            rd_addr_b = bk_reg;
        end
        else if (ctl.draw_rd)
        begin
            rd_addr_a = draw_a;
            rd_addr_b = draw_b;
        end
        else if (idx_reg >= srg_pkg::LAG_LEN)
        begin
            rd_addr_a = '0;
        end
    end

    // Write port select
    always_comb
    begin
        we = 1'b0;
        wa = ak_reg;
        wd = diff;
        if (ctl.fill_init)
        begin
            we = 1'b1;
            wa = srg_pkg::LAG_LAST;
            wd = {{(DW-srg_pkg::MAG_W){1'b0}}, mj_init};
        end
        else if (ctl.fill_step)
        begin
            we = 1'b1;
            wa = pos_reg - 6'd1;
            wd = mk_reg;
        end
        else if (ctl.mix_wr)
        begin
            we = 1'b1;
            wa = ak_reg;
            wd = diff;
        end
        else if (ctl.draw_wr)
        begin
            we = 1'b1;
            wa = first_reg - 6'd1;
            wd = diff;
        end
        else if (ctl.wr && (idx_reg < srg_pkg::LAG_LEN))
        begin
            we = 1'b1;
            wa = idx_reg;
            wd = (val_reg > srg_pkg::RG_MAX) ? srg_pkg::RG_MAX : val_reg;
        end
    end

    // Table memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            lag_mem[wa] <= wd;
        end
        if (rd_en)
        begin
            mem_a_reg <= lag_mem[rd_addr_a];
            mem_b_reg <= lag_mem[rd_addr_b];
        end
    end

    // Valid bits and their read registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lag_vld_reg <= '0;
            vld_a_reg   <= 1'b0;
            vld_b_reg   <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                lag_vld_reg[wa] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_a_reg <= lag_vld_reg[rd_addr_a];
                vld_b_reg <= lag_vld_reg[rd_addr_b];
            end
        end
    end

    // Item capture and seeding registers
    always_ff @(posedge clk)
    begin
        if (ctl.cap)
        begin
            seed_reg <= seed;
            idx_reg  <= word_index;
            val_reg  <= word_value;
        end
        if (ctl.mag_ld)
        begin
            mag_reg <= mag_sat;
        end
        pos_reg <= pos_next;
        ak_reg  <= ak_next;
        bk_reg  <= bk_next;
        mj_reg  <= mj_next;
        mk_reg  <= mk_next;
    end

    // Fill and mix pointer updates
    always_comb
    begin
        pos_next = pos_reg;
        ak_next  = ak_reg;
        bk_next  = bk_reg;
        mj_next  = mj_reg;
        mk_next  = mk_reg;
        pos_sum  = {1'b0, pos_reg} + {1'b0, srg_pkg::FILL_STEP};
        if (ctl.fill_init)
        begin
            pos_next = srg_pkg::FILL_STEP;
            ak_next  = '0;
            bk_next  = srg_pkg::MIX_OFFSET;
            mj_next  = {{(DW-srg_pkg::MAG_W){1'b0}}, mj_init};
            mk_next  = {{(DW-1){1'b0}}, 1'b1};
        end
        else if (ctl.fill_step)
        begin
            pos_next = (pos_sum >= {1'b0, srg_pkg::LAG_LEN})
                       ? IW'(pos_sum - {1'b0, srg_pkg::LAG_LEN}) : pos_sum[IW-1:0];
            mk_next  = srg_pkg::sub_mod(mj_reg, mk_reg);
            mj_next  = mk_reg;
        end
        else if (ctl.mix_wr)
        begin
            ak_next = (ak_reg == srg_pkg::LAG_LAST) ? '0 : ak_reg + 6'd1;
            bk_next = (bk_reg == srg_pkg::LAG_LAST) ? '0 : bk_reg + 6'd1;
        end
    end

    // Index registers
    always_comb
    begin
        first_next  = first_reg;
        second_next = second_reg;
        if (ctl.seed_done)
        begin
            first_next  = '0;
            second_next = srg_pkg::SECOND_START;
        end
        else if (ctl.draw_rd)
        begin
            first_next  = draw_a + 6'd1;
            second_next = draw_b + 6'd1;
        end
        else if (ctl.wr && (idx_reg == srg_pkg::SEL_FIRST))
        begin
            first_next = (val_reg > 30'd55) ? srg_pkg::LAG_LEN : val_reg[IW-1:0];
        end
        else if (ctl.wr && (idx_reg == srg_pkg::SEL_SECOND))
        begin
            second_next = (val_reg > 30'd55) ? srg_pkg::LAG_LEN : val_reg[IW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= '0;
            second_reg <= '0;
        end
        else
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    // State word for a read
    always_comb
    begin
        if (idx_reg < srg_pkg::LAG_LEN)
        begin
            state_word = rd_a;
        end
        else if (idx_reg == srg_pkg::SEL_FIRST)
        begin
            state_word = {{(DW-IW){1'b0}}, first_reg};
        end
        else if (idx_reg == srg_pkg::SEL_SECOND)
        begin
            state_word = {{(DW-IW){1'b0}}, second_reg};
        end
        else
        begin
            state_word = '0;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.draw_wr || ctl.read_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.draw_wr)
        begin
            data_reg <= diff;
            kind_reg <= srg_pkg::KIND_RANDOM;
        end
        else if (ctl.read_out)
        begin
            data_reg <= state_word;
            kind_reg <= srg_pkg::KIND_STATE;
        end
    end

    assign sts.out_free = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign data         = data_reg;
    assign kind         = kind_reg;

endmodule
